// ===== rtl/linear_probe_hash_map_macros.svh =====
// ----------------------------------------------------------------------------
// Linear probe hash map assertion macros
// Shared property shapes for the checker, sampled on the rising clock edge
// and disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define LPH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lph_checker: property violated");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define LPH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lph_checker: property violated");

`endif

// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Payload types, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lph_pkg;

    localparam int BUCKETS_DEFAULT     = 256;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int CMD_WIDTH      = 2;
    localparam int KEY_WIDTH      = 64;
    localparam int DATA_WIDTH     = 32;
    localparam int STATUS_WIDTH   = 2;
    localparam int MAX_USED_WIDTH = 8;
    localparam int USED_WIDTH     = 9;
    localparam int BST_WIDTH      = 2;

    localparam logic [MAX_USED_WIDTH-1:0] MAX_USED_RESET = 8'd179;

    // Operation codes.
    localparam logic [CMD_WIDTH-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_FIND   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd2;

    // Bucket states.
    localparam logic [BST_WIDTH-1:0] BST_FREE = 2'd0;
    localparam logic [BST_WIDTH-1:0] BST_USED = 2'd1;
    localparam logic [BST_WIDTH-1:0] BST_TOMB = 2'd2;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]  cmd;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] value;
    } lph_in_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [DATA_WIDTH-1:0]   found_value;
    } lph_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load_item;
        logic hash_step;
        logic load_slot;
        logic advance;
        logic finish;
    } lph_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic probe_done;
        logic out_free;
    } lph_status_t;

endpackage

// ===== rtl/lph_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lph_datapath.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map datapath
// Item registers, bucket hash, probe pointer, bucket memories, load counter
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lph_datapath #(
    parameter int BUCKETS     = lph_pkg::BUCKETS_DEFAULT,
    parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lph_pkg::lph_cmd_t                     ctl,
    output lph_pkg::lph_status_t                  stat,
    input  lph_pkg::lph_in_t                      in_data,
    input  logic                                  cfg_wr,
    input  logic [lph_pkg::MAX_USED_WIDTH-1:0]    cfg_data,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output lph_pkg::lph_out_t                     out_data
);

    localparam int SW = $clog2(BUCKETS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(BUCKETS - 1);

    lph_pkg::lph_in_t                      item_reg;
    lph_pkg::lph_out_t                     out_reg;
    logic                                  out_valid_reg;
    logic [lph_pkg::MAX_USED_WIDTH-1:0]    max_used_reg;
    logic [lph_pkg::USED_WIDTH-1:0]        used_reg;
    logic [SW-1:0]                         slot_reg;
    logic [SW-1:0]                         slot_next;
    logic [SW-1:0]                         cnt_reg;
    logic [SW-1:0]                         cnt_next;
    logic [SW-1:0]                         clr_reg;

    logic [SW-1:0]                         hash_slot;
    logic                                  hash_done;

    logic [lph_pkg::BST_WIDTH-1:0]         st_rd;
    logic [lph_pkg::KEY_WIDTH-1:0]         key_rd;
    logic [VALUE_WIDTH-1:0]                val_rd;

    logic                                  over_limit;
    logic                                  is_last;
    logic                                  key_hit;
    logic                                  done;
    logic [lph_pkg::STATUS_WIDTH-1:0]      res_status;
    logic [lph_pkg::DATA_WIDTH-1:0]        res_found;
    logic                                  st_we_probe;
    logic [lph_pkg::BST_WIDTH-1:0]         st_wval;
    logic                                  kv_we;
    logic                                  inc_used;

    logic                                  st_we;
    logic [SW-1:0]                         st_waddr;
    logic [lph_pkg::BST_WIDTH-1:0]         st_wdata;

    // Home bucket of the key: the low bits for a power-of-two table, else the
    // sum of the constant residues of the set key bits, folded in eight bits a
    // cycle and brought back below BUCKETS by compare and subtract.
    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0)
        begin : g_pow2
            assign hash_slot = item_reg.key[SW-1:0];
            assign hash_done = 1'b1;
        end
        else
        begin : g_fold
            localparam int AW = SW + 4;
            localparam logic [AW-1:0] B_FULL = AW'(BUCKETS);

            logic [SW-1:0] weight [64];
            logic [AW-1:0] term [8];
            logic [AW-1:0] pair [4];
            logic [AW-1:0] acc_sum;
            logic [AW-1:0] acc_red;
            logic [SW-1:0] rem_reg;
            logic [3:0]    hcnt_reg;

            // Residue of each key bit's place value.
            for (genvar gj = 0; gj < 64; gj++)
            begin : g_weight
                assign weight[gj] = SW'((64'd1 << gj) % 64'(BUCKETS));
            end

            for (genvar gt = 0; gt < 8; gt++)
            begin : g_term
                assign term[gt] = item_reg.key[{hcnt_reg[2:0], 3'(gt)}]
                                ? {4'b0000, weight[{hcnt_reg[2:0], 3'(gt)}]} : '0;
            end

            for (genvar gp = 0; gp < 4; gp++)
            begin : g_pair
                assign pair[gp] = term[2*gp] + term[2*gp+1];
            end

            // The running remainder plus eight residues stays below 9 * BUCKETS.
            assign acc_sum = ({4'b0000, rem_reg} + (pair[0] + pair[1]))
                           + (pair[2] + pair[3]);

            always_comb
            begin
                acc_red = acc_sum;
                for (int k = 3; k >= 0; k--)
                begin
                    if (acc_red >= (B_FULL << k))
                    begin
                        acc_red = acc_red - (B_FULL << k);
                    end
                end
            end

            assign hash_slot = rem_reg;
            assign hash_done = hcnt_reg[3];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rem_reg  <= '0;
                    hcnt_reg <= '0;
                end
                else if (ctl.load_item)
                begin
                    rem_reg  <= '0;
                    hcnt_reg <= '0;
                end
                else if (ctl.hash_step)
                begin
                    rem_reg  <= acc_red[SW-1:0];
                    hcnt_reg <= hcnt_reg + 4'd1;
                end
            end
        end
    endgenerate

    // The memories read at the next pointer, so their data always belongs to
    // the bucket that slot_reg names.
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (ctl.load_slot)
        begin
            slot_next = hash_slot;
            cnt_next  = '0;
        end
        else if (ctl.advance)
        begin
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SW'(1);
            cnt_next  = cnt_reg + SW'(1);
        end
    end

    assign over_limit = ({1'b0, used_reg} + 10'd1) > {2'b00, max_used_reg};
    assign is_last    = (cnt_reg == LAST_SLOT);
    assign key_hit    = (st_rd == lph_pkg::BST_USED) && (key_rd == item_reg.key);

    always_comb
    begin
        done        = 1'b0;
        res_status  = lph_pkg::STATUS_MISSING;
        res_found   = '0;
        st_we_probe = 1'b0;
        st_wval     = lph_pkg::BST_USED;
        kv_we       = 1'b0;
        inc_used    = 1'b0;
        unique case (item_reg.cmd)
            lph_pkg::CMD_INSERT:
            begin
                priority if (over_limit)
                begin
                    done       = 1'b1;
                    res_status = lph_pkg::STATUS_FULL;
                end
                else if (st_rd != lph_pkg::BST_USED)
                begin
                    done        = 1'b1;
                    res_status  = lph_pkg::STATUS_OK;
                    st_we_probe = 1'b1;
                    kv_we       = 1'b1;
                    inc_used    = (st_rd == lph_pkg::BST_FREE);
                end
                else if (is_last)
                begin
                    done       = 1'b1;
                    res_status = lph_pkg::STATUS_FULL;
                end
                else
                begin
                    done = 1'b0;
                end
            end
            lph_pkg::CMD_REMOVE, lph_pkg::CMD_FIND:
            begin
                priority if (st_rd == lph_pkg::BST_FREE)
                begin
                    done = 1'b1;
                end
                else if (key_hit)
                begin
                    done       = 1'b1;
                    res_status = lph_pkg::STATUS_OK;
                    if (item_reg.cmd == lph_pkg::CMD_REMOVE)
                    begin
                        st_we_probe = 1'b1;
                        st_wval     = lph_pkg::BST_TOMB;
                    end
                    else
                    begin
                        res_found = lph_pkg::DATA_WIDTH'(val_rd);
                    end
                end
                else if (is_last)
                begin
                    done = 1'b1;
                end
                else
                begin
                    done = 1'b0;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign st_we    = ctl.clear | (ctl.finish & st_we_probe);
    assign st_waddr = ctl.clear ? clr_reg : slot_reg;
    assign st_wdata = ctl.clear ? lph_pkg::BST_FREE : st_wval;

    lph_ram #(
        .WIDTH (lph_pkg::BST_WIDTH),
        .DEPTH (BUCKETS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (slot_next),
        .rdata (st_rd)
    );

    lph_ram #(
        .WIDTH (lph_pkg::KEY_WIDTH),
        .DEPTH (BUCKETS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ctl.finish & kv_we),
        .waddr (slot_reg),
        .wdata (item_reg.key),
        .raddr (slot_next),
        .rdata (key_rd)
    );

    lph_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (BUCKETS)
    ) u_value_ram (
        .clk   (clk),
        .we    (ctl.finish & kv_we),
        .waddr (slot_reg),
        .wdata (VALUE_WIDTH'(item_reg.value)),
        .raddr (slot_next),
        .rdata (val_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_used_reg  <= lph_pkg::MAX_USED_RESET;
            used_reg      <= '0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
            if (cfg_wr)
            begin
                max_used_reg <= cfg_data;
            end
            if (ctl.clear)
            begin
                clr_reg <= clr_reg + SW'(1);
            end
            if (ctl.finish && inc_used)
            begin
                used_reg <= used_reg + lph_pkg::USED_WIDTH'(1);
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= in_data;
        end
        if (ctl.finish)
        begin
            out_reg.status      <= res_status;
            out_reg.found_value <= res_found;
        end
    end

    assign stat.clear_last = (clr_reg == LAST_SLOT);
    assign stat.hash_done  = hash_done;
    assign stat.probe_done = done;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/lph_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map controller
// Sequences the clearing pass, item capture, hashing and the bucket probe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lph_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lph_pkg::lph_status_t stat,
    output lph_pkg::lph_cmd_t    ctl
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } lph_state_t;

    lph_state_t state_reg;
    lph_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.hash_done)
                begin
                    ctl.load_slot = 1'b1;
                    state_next    = S_PROBE;
                end
                else
                begin
                    ctl.hash_step = 1'b1;
                end
            end
            S_PROBE:
            begin
                // A finished item waits here until the result register frees.
                if (stat.probe_done)
                begin
                    if (stat.out_free)
                    begin
                        ctl.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map
// Open-addressing hash table with linear probing, insert, remove and find.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_stall carrying cmd, key and value; each item
// produces exactly one result item on out_valid/out_stall with status and
// found_value. The table handles one item at a time: in_stall is high from
// acceptance until the item's result has been loaded into the output register.
// For a power-of-two bucket count the home bucket is the low key bits. An item
// is answered when its probe ends, and the next item can be accepted in the
// cycle after its result is loaded. The probe reads one bucket per cycle from
// the bucket memories; other bucket counts first hash the key, eight key bits
// a cycle. After reset the block clears the bucket state memory, one bucket a
// cycle, with in_stall high; max_used resets to 179 and the use count to zero.
// The max_used register is written on cfg_valid with cfg_ready, which is always
// high; write it only while the table is idle.
// A stalled result stays in the output register; the next item may be accepted
// meanwhile, but its result is held back until the register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_map #(
    parameter int BUCKETS     = lph_pkg::BUCKETS_DEFAULT,
    parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  lph_pkg::lph_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output lph_pkg::lph_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lph_pkg::MAX_USED_WIDTH-1:0] cfg_data
);

    lph_pkg::lph_cmd_t    ctl;
    lph_pkg::lph_status_t stat;

    // The register port never back-pressures.
    assign cfg_ready = 1'b1;

    // The controller owns the sequence; it never touches payload.
    lph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The datapath holds the bucket memories, the probe pointer, the use
    // count and the output register.
    lph_datapath #(
        .BUCKETS     (BUCKETS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/lph_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map checker
// Port-level properties of the hash map, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_map_macros.svh"

module lph_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input lph_pkg::lph_out_t out_data
);

    // Only one item is in flight, so an accepted item closes the input.
    `LPH_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A new result is only produced by an item that was being worked on.
    `LPH_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A stalled result is held unchanged.
    `LPH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Only a successful find carries data; a result with any status other than OK must read zero.
    `LPH_ASSERT_IMP(a_found_zero, clk, rst_n, out_valid && (out_data.status != lph_pkg::STATUS_OK), out_data.found_value == '0)

    // The status code is one of the three defined results.
    `LPH_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, (out_data.status == lph_pkg::STATUS_OK) || (out_data.status == lph_pkg::STATUS_MISSING) || (out_data.status == lph_pkg::STATUS_FULL))

endmodule

bind linear_probe_hash_map lph_checker u_lph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
